// ===== sv/deadline_sorted_event_queue_defines.svh =====
// assertion macros for the deadline sorted event queue
// used by files that carry concurrent checks; no other dependencies
`ifndef DEADLINE_SORTED_EVENT_QUEUE_DEFINES_SVH
`define DEADLINE_SORTED_EVENT_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DSEQ_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define DSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSEQ_ASSERT(lbl, expr, msg)
`define DSEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/dseq_pkg.sv =====
// types and codes shared by the event queue modules
// no dependencies
package dseq_pkg;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_READD = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic {
        RES_ACK    = 1'b0,
        RES_EXPIRE = 1'b1
    } res_kind_t;

    typedef enum logic {
        ST_OK     = 1'b0,
        ST_NO_IVL = 1'b1
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RM_RD,
        S_RM_CHK,
        S_IV_RD,
        S_IV_CHK,
        S_ADD,
        S_INS,
        S_INS_DL,
        S_INS_CMP,
        S_ACK,
        S_TK_RD,
        S_TK_DL,
        S_TK_CMP,
        S_TK_END
    } state_t;

    // ram port enables
    typedef struct packed {
        logic re;
        logic we;
    } mem_en_t;

    localparam int SLOT_IN_W = 4;
    localparam int TIME_W    = 64;

endpackage

// ===== sv/deadline_sorted_event_queue.sv =====
// Deadline sorted timer event queue, top level.
// s_ channel: one transfer per command. tuser carries the kind (add, re-add, tick),
// tdata the slot, interval and current time. m_ channel: acknowledgements for add and
// re-add (one transfer, tlast high) and expired events for a tick (one transfer per
// popped slot, tlast high on the final one; none if nothing expired).
// Commands are taken one at a time; s_tready is high only while the sequencer idles.
// Every step goes through three single port-pair rams (order list, deadlines,
// intervals) with registered reads, so the walk sets the timing:
// an add reads the stored interval, then walks from the tail, reading each entry
// and its deadline and moving it up while its deadline is later; a queued slot is
// first unlinked by a read of every queued entry in turn;
// a tick reads the head entry and its deadline and pops it while it has expired.
// Reset empties the queue and forgets all stored intervals at once; there is no
// clearing pass. A result waits in an output register; while m_tready is low the
// sequencer holds at the next result it has to send.
// depends on dseq_pkg, dseq_ram and dseq_ctrl
module deadline_sorted_event_queue
    import dseq_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // event_slot[3:0], interval[67:4], now[131:68], zero pad
    input  logic [1:0]   s_tuser,  // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,  // slot_out[3:0], status[4], zero pad
    output logic         m_tuser,  // result_kind[0]
    output logic         m_tlast
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    mem_en_t              ord_en, dl_en, iv_en;
    logic [SW-1:0]        ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic [SW-1:0]        dl_waddr, dl_raddr, iv_waddr, iv_raddr;
    logic [TIME_W-1:0]    dl_wdata, dl_rdata, iv_wdata, iv_rdata;
    res_kind_t            out_kind;
    status_t              out_status;
    logic [SLOT_IN_W-1:0] out_slot;

    dseq_ctrl #(.SLOTS(SLOTS), .SW(SW), .CW(CW)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (kind_t'(s_tuser)),
        .in_slot     (s_tdata[3:0]),
        .in_interval (s_tdata[67:4]),
        .in_now      (s_tdata[131:68]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_slot    (out_slot),
        .out_status  (out_status),
        .out_last    (m_tlast),
        .ord_en      (ord_en),
        .ord_waddr   (ord_waddr),
        .ord_wdata   (ord_wdata),
        .ord_raddr   (ord_raddr),
        .ord_rdata   (ord_rdata),
        .dl_en       (dl_en),
        .dl_waddr    (dl_waddr),
        .dl_wdata    (dl_wdata),
        .dl_raddr    (dl_raddr),
        .dl_rdata    (dl_rdata),
        .iv_en       (iv_en),
        .iv_waddr    (iv_waddr),
        .iv_wdata    (iv_wdata),
        .iv_raddr    (iv_raddr),
        .iv_rdata    (iv_rdata)
    );

    dseq_ram #(.WIDTH(SW), .DEPTH(SLOTS), .AW(SW)) u_order_ram (
        .aclk  (aclk),
        .en    (ord_en),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    dseq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS), .AW(SW)) u_deadline_ram (
        .aclk  (aclk),
        .en    (dl_en),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    dseq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS), .AW(SW)) u_interval_ram (
        .aclk  (aclk),
        .en    (iv_en),
        .waddr (iv_waddr),
        .wdata (iv_wdata),
        .raddr (iv_raddr),
        .rdata (iv_rdata)
    );

    assign m_tdata = {3'b000, out_status, out_slot};
    assign m_tuser = out_kind;

endmodule

// ===== sv/dseq_ram.sv =====
// simple dual port ram, one write and one registered read port
// depends on dseq_pkg
module dseq_ram
    import dseq_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  mem_en_t          en,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en.we) begin
            mem[waddr] <= wdata;
        end
        if (en.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dseq_ctrl.sv =====
// sequencer for the event queue: removal, insertion walk and expiry pops
// depends on dseq_pkg and the assertion macro header
`include "deadline_sorted_event_queue_defines.svh"
module dseq_ctrl
    import dseq_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int SW    = 4,
    parameter int CW    = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kind_t                in_kind,
    input  logic [SLOT_IN_W-1:0] in_slot,
    input  logic [TIME_W-1:0]    in_interval,
    input  logic [TIME_W-1:0]    in_now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_kind_t            out_kind,
    output logic [SLOT_IN_W-1:0] out_slot,
    output status_t              out_status,
    output logic                 out_last,
    // order list ram
    output mem_en_t              ord_en,
    output logic [SW-1:0]        ord_waddr,
    output logic [SW-1:0]        ord_wdata,
    output logic [SW-1:0]        ord_raddr,
    input  logic [SW-1:0]        ord_rdata,
    // deadline ram
    output mem_en_t              dl_en,
    output logic [SW-1:0]        dl_waddr,
    output logic [TIME_W-1:0]    dl_wdata,
    output logic [SW-1:0]        dl_raddr,
    input  logic [TIME_W-1:0]    dl_rdata,
    // interval ram
    output mem_en_t              iv_en,
    output logic [SW-1:0]        iv_waddr,
    output logic [TIME_W-1:0]    iv_wdata,
    output logic [SW-1:0]        iv_raddr,
    input  logic [TIME_W-1:0]    iv_rdata
);

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [TIME_W-1:0]     ival_reg, ival_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [TIME_W-1:0]     dl_reg, dl_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic [SW-1:0]         head_reg, head_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [SLOTS-1:0]      queued_reg, queued_next;
    logic [SLOTS-1:0]      ivld_reg, ivld_next;
    status_t               status_reg, status_next;
    logic [SW-1:0]         entry_reg, entry_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [SW-1:0]         pend_slot_reg, pend_slot_next;
    logic                  m_valid_reg, m_valid_next;
    res_kind_t             m_kind_reg, m_kind_next;
    logic [SLOT_IN_W-1:0]  m_slot_reg, m_slot_next;
    status_t               m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    logic                  can_emit;
    logic                  slot_ok;
    logic [TIME_W-1:0]     stored_ival;

    // logical list position to ram address, list is circular from head
    function automatic logic [SW-1:0] phys(input logic [SW-1:0] h, input logic [CW-1:0] i);
        logic [SW:0] sum;
        sum = {1'b0, h} + (SW+1)'(i);
        if (sum >= (SW+1)'(SLOTS)) begin
            sum = sum - (SW+1)'(SLOTS);
        end
        return sum[SW-1:0];
    endfunction

    assign can_emit    = !m_valid_reg || out_ready;
    assign slot_ok     = (32'(in_slot) < SLOTS);
    assign stored_ival = ivld_reg[slot_reg] ? iv_rdata : '0;
    assign in_ready    = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            head_reg     <= '0;
            queued_reg   <= '0;
            ivld_reg     <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            status_reg   <= ST_OK;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            queued_reg   <= queued_next;
            ivld_reg     <= ivld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        ival_reg      <= ival_next;
        now_reg       <= now_next;
        dl_reg        <= dl_next;
        idx_reg       <= idx_next;
        entry_reg     <= entry_next;
        pend_slot_reg <= pend_slot_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_status_reg  <= m_status_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        ival_next      = ival_reg;
        now_next       = now_reg;
        dl_next        = dl_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        queued_next    = queued_reg;
        ivld_next      = ivld_reg;
        status_next    = status_reg;
        entry_next     = entry_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        m_valid_next   = m_valid_reg && !out_ready;
        m_kind_next    = m_kind_reg;
        m_slot_next    = m_slot_reg;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        ord_en         = '0;
        ord_waddr      = '0;
        ord_wdata      = '0;
        ord_raddr      = '0;
        dl_en          = '0;
        dl_waddr       = slot_reg;
        dl_wdata       = dl_reg;
        dl_raddr       = ord_rdata;
        iv_en          = '0;
        iv_waddr       = slot_reg;
        iv_wdata       = ival_reg;
        iv_raddr       = slot_reg;

        case (state_reg)
            S_IDLE: begin
                kind_next = in_kind;
                slot_next = SW'(in_slot);
                ival_next = in_interval;
                now_next  = in_now;
                idx_next  = '0;
                found_next = 1'b0;
                if (in_valid) begin
                    if (in_kind == KIND_TICK) begin
                        state_next = S_TK_RD;
                    end else if ((in_kind == KIND_ADD || in_kind == KIND_READD) && slot_ok) begin
                        state_next = queued_reg[SW'(in_slot)] ? S_RM_RD : S_IV_RD;
                    end
                end
            end
            S_RM_RD: begin
                ord_en.re  = 1'b1;
                ord_raddr  = phys(head_reg, idx_reg);
                state_next = S_RM_CHK;
            end
            S_RM_CHK: begin
                // entries after the removed one move down by one
                if (found_reg) begin
                    ord_en.we = 1'b1;
                    ord_waddr = phys(head_reg, idx_reg - CW'(1));
                    ord_wdata = ord_rdata;
                end
                if (ord_rdata == slot_reg) begin
                    found_next = 1'b1;
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == cnt_reg) begin
                    cnt_next              = cnt_reg - CW'(1);
                    queued_next[slot_reg] = 1'b0;
                    state_next            = S_IV_RD;
                end else begin
                    state_next = S_RM_RD;
                end
            end
            S_IV_RD: begin
                iv_en.re   = 1'b1;
                state_next = S_IV_CHK;
            end
            S_IV_CHK: begin
                state_next = S_ADD;
                if (kind_reg == KIND_READD && ival_reg == '0) begin
                    if (stored_ival == '0) begin
                        status_next = ST_NO_IVL;
                        state_next  = S_ACK;
                    end else begin
                        ival_next = stored_ival;
                    end
                end
            end
            S_ADD: begin
                dl_next             = now_reg + ival_reg;
                iv_en.we            = 1'b1;
                ivld_next[slot_reg] = 1'b1;
                idx_next            = cnt_reg;
                state_next          = S_INS;
            end
            S_INS: begin
                // walk from the tail towards the head
                dl_en.we = 1'b1;
                if (idx_reg == '0) begin
                    ord_en.we             = 1'b1;
                    ord_waddr             = head_reg;
                    ord_wdata             = slot_reg;
                    cnt_next              = cnt_reg + CW'(1);
                    queued_next[slot_reg] = 1'b1;
                    state_next            = S_ACK;
                end else begin
                    ord_en.re  = 1'b1;
                    ord_raddr  = phys(head_reg, idx_reg - CW'(1));
                    state_next = S_INS_DL;
                end
            end
            S_INS_DL: begin
                entry_next = ord_rdata;
                dl_en.re   = 1'b1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP: begin
                ord_en.we = 1'b1;
                ord_waddr = phys(head_reg, idx_reg);
                if (dl_rdata > dl_reg) begin
                    ord_wdata  = entry_reg;
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_INS;
                end else begin
                    ord_wdata             = slot_reg;
                    cnt_next              = cnt_reg + CW'(1);
                    queued_next[slot_reg] = 1'b1;
                    state_next            = S_ACK;
                end
            end
            S_ACK: begin
                if (can_emit) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = RES_ACK;
                    m_slot_next   = SLOT_IN_W'(slot_reg);
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
            end
            S_TK_RD: begin
                if (cnt_reg == '0) begin
                    state_next = S_TK_END;
                end else begin
                    ord_en.re  = 1'b1;
                    ord_raddr  = head_reg;
                    state_next = S_TK_DL;
                end
            end
            S_TK_DL: begin
                entry_next = ord_rdata;
                dl_en.re   = 1'b1;
                state_next = S_TK_CMP;
            end
            S_TK_CMP: begin
                if (now_reg >= dl_rdata) begin
                    // an earlier pop goes out once this one proves it was not last
                    if (!pend_vld_reg || can_emit) begin
                        if (pend_vld_reg) begin
                            m_valid_next  = 1'b1;
                            m_kind_next   = RES_EXPIRE;
                            m_slot_next   = SLOT_IN_W'(pend_slot_reg);
                            m_status_next = ST_OK;
                            m_last_next   = 1'b0;
                        end
                        pend_vld_next          = 1'b1;
                        pend_slot_next         = entry_reg;
                        head_next              = phys(head_reg, CW'(1));
                        cnt_next               = cnt_reg - CW'(1);
                        queued_next[entry_reg] = 1'b0;
                        state_next             = S_TK_RD;
                    end
                end else begin
                    state_next = S_TK_END;
                end
            end
            S_TK_END: begin
                if (!pend_vld_reg) begin
                    state_next = S_IDLE;
                end else if (can_emit) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = RES_EXPIRE;
                    m_slot_next   = SLOT_IN_W'(pend_slot_reg);
                    m_status_next = ST_OK;
                    m_last_next   = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = m_valid_reg;
    assign out_kind   = m_kind_reg;
    assign out_slot   = m_slot_reg;
    assign out_status = m_status_reg;
    assign out_last   = m_last_reg;

    `DSEQ_ASSERT(a_cnt_range, cnt_reg <= CW'(SLOTS), "queue count exceeds slot count")
    `DSEQ_ASSERT(a_cnt_flags, $countones(queued_reg) == int'(cnt_reg), "flags disagree with count")
    `DSEQ_ASSERT(a_pend_tick, !pend_vld_reg || state_reg == S_TK_RD || state_reg == S_TK_DL || state_reg == S_TK_CMP || state_reg == S_TK_END, "pending expiry outside tick")
    `DSEQ_ASSERT_NEXT(a_empty_tick, state_reg == S_TK_RD && cnt_reg == '0, state_reg == S_TK_END, "empty queue tick did not finish")

endmodule
